/* rtl/core/sct_pkg.sv */
// Shared constants, types and the sine table for the sine/cosine table interpolator.
// No dependencies; every other file in rtl/core takes its names from here.
`default_nettype none

package sct_pkg;

  // Angle and result formats
  localparam int ANGLE_W             = 32;
  localparam int ANGLE_FRACTION_BITS = 16;
  localparam int VALUE_W             = 16;

  // Table geometry; the entry count is a power of two
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int PHASE_W       = 32;
  localparam int FRAC_W        = PHASE_W - IDX_W;

  // Table entries reach +1.0, hence one bit beyond Q1.15
  localparam int ENTRY_W = VALUE_W + 1;
  localparam int DIFF_W  = ENTRY_W + 1;
  localparam int PROD_W  = DIFF_W + FRAC_W + 1;
  localparam int ACC_W   = PROD_W + 1;
  localparam int RES_W   = ACC_W - FRAC_W;

  // round(2^32 / (2*pi)) and pi in Q2.30
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam longint      PI_Q30         = 64'sd3373259426;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(64'h4000_0000);

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef entry_t rom_t [TABLE_ENTRIES];

  // Restoring long division, one quotient bit per step; the divisor stays small
  function automatic longint unsigned udiv_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine table over one turn, built at elaboration: fold to the first quadrant,
  // Taylor series to x^17/17! in Q30 with truncated terms, round half up to Q1.15.
  function automatic rom_t build_rom();
    rom_t              r;
    longint            x;
    longint            sum;
    longint            q;
    longint unsigned   ux;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   den;
    bit                neg;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      x   = (2 * PI_Q30 * longint'(k)) / TABLE_ENTRIES;
      neg = 1'b0;
      if (x > PI_Q30) begin
        x   = x - PI_Q30;
        neg = 1'b1;
      end
      if (2 * x > PI_Q30) begin
        x = PI_Q30 - x;
      end
      ux   = longint'(x);
      x2   = (ux * ux) >> 30;
      term = ux;
      sum  = longint'(ux);
      for (int n = 1; n <= 8; n++) begin
        den  = longint'((2 * n) * (2 * n + 1));
        term = udiv_u64((term * x2) >> 30, den);
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q    = (sum + (64'sd1 <<< 14)) >>> 15;
      r[k] = neg ? ENTRY_W'(-q) : ENTRY_W'(q);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

`default_nettype wire

/* rtl/core/sct_if.sv */
// Valid/ready channel interfaces for the sine/cosine table interpolator.
// Depends on sct_pkg for field widths.
`default_nettype none

interface sct_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [sct_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, output req_type, output angle, input ready);
  modport sink   (input valid, input req_type, input angle, output ready);
endinterface

interface sct_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sct_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

/* rtl/core/sine_cosine_table_interpolator_top.sv */
// Sine/cosine interpolator: a five-register pipeline from angle word to result word.
// Depends on sct_pkg (table, formats) and sct_if (channel interfaces).
//
// Give an angle in radians (signed Q15.16) with req_type 0 for sine or 1 for
// cosine; the result is the Q1.15 value from a 64-entry table over one turn,
// linearly interpolated between neighboring entries, with +1.0 saturated to
// 0x7FFF. Any angle wraps correctly, negative ones included. One word enters
// and one leaves every cycle while out_bus.ready holds; each word passes through
// the five registers in order, ending in the output register. The stages are
// the input register, the angle-to-phase multiplier, the two table reads, the
// interpolation multiplier and the final add and saturate. Each stage holds
// its own valid bit and stalls only when the stage after it is full and
// blocked, so back-pressure never drops or repeats a word and empty slots are
// squeezed out.
`default_nettype none

module sine_cosine_table_interpolator_top (
  input  wire logic      clk,
  input  wire logic      rst_n,
  sct_in_if.sink         in_bus,
  sct_out_if.source      out_bus
);

  // Stage 1: input register
  logic                                   v1_r;
  logic                                   req1_r;
  logic signed [sct_pkg::ANGLE_W-1:0]     ang1_r;

  // Stage 2: phase in turns
  logic                                   v2_r;
  logic        [sct_pkg::PHASE_W-1:0]     phase2_r;

  // Stage 3: table entries and fraction
  logic                                   v3_r;
  sct_pkg::entry_t                        lo3_r;
  logic signed [sct_pkg::DIFF_W-1:0]      d3_r;
  logic        [sct_pkg::FRAC_W-1:0]      f3_r;

  // Stage 4: interpolation product
  logic                                   v4_r;
  sct_pkg::entry_t                        lo4_r;
  logic signed [sct_pkg::PROD_W-1:0]      prod4_r;

  // Stage 5: output register
  logic                                   v5_r;
  logic signed [sct_pkg::VALUE_W-1:0]     value5_r;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_bus.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_bus.ready  = rdy1;
  assign out_bus.valid = v5_r;
  assign out_bus.value = value5_r;

  // Angle times 1/(2*pi); the phase is the Q0.32 slice above the angle fraction
  logic signed [62:0]                 mult1;
  logic        [sct_pkg::PHASE_W-1:0] phase_nxt;

  always_comb begin
    mult1     = ang1_r * $signed({1'b0, sct_pkg::INV_TWO_PI_Q32});
    phase_nxt = mult1[sct_pkg::ANGLE_FRACTION_BITS + sct_pkg::PHASE_W - 1 :
                      sct_pkg::ANGLE_FRACTION_BITS];
    if (req1_r) begin
      phase_nxt = phase_nxt + sct_pkg::QUARTER_TURN;
    end
  end

  // Table reads at the index and its successor, which wraps to entry zero
  logic [sct_pkg::IDX_W-1:0]         idx2;
  logic [sct_pkg::IDX_W-1:0]         nxt2;
  sct_pkg::entry_t                   lo_nxt;
  sct_pkg::entry_t                   hi_nxt;
  logic signed [sct_pkg::DIFF_W-1:0] d_nxt;

  always_comb begin
    idx2   = phase2_r[sct_pkg::PHASE_W-1 -: sct_pkg::IDX_W];
    nxt2   = idx2 + sct_pkg::IDX_W'(1);
    lo_nxt = sct_pkg::SINE_ROM[idx2];
    hi_nxt = sct_pkg::SINE_ROM[nxt2];
    d_nxt  = sct_pkg::DIFF_W'(hi_nxt) - sct_pkg::DIFF_W'(lo_nxt);
  end

  logic signed [sct_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = d3_r * $signed({1'b0, f3_r});

  // Add the base entry and half an LSB, drop the fraction, saturate
  logic signed [sct_pkg::ACC_W-1:0]   acc4;
  logic signed [sct_pkg::RES_W-1:0]   res4;
  logic signed [sct_pkg::VALUE_W-1:0] value_nxt;

  always_comb begin
    acc4 = (sct_pkg::ACC_W'(lo4_r) <<< sct_pkg::FRAC_W)
         + sct_pkg::ACC_W'(prod4_r)
         + (sct_pkg::ACC_W'(1) <<< (sct_pkg::FRAC_W - 1));
    res4 = acc4[sct_pkg::ACC_W-1:sct_pkg::FRAC_W];
    if (res4 > sct_pkg::RES_W'(sct_pkg::VALUE_MAX)) begin
      value_nxt = sct_pkg::VALUE_MAX;
    end else if (res4 < sct_pkg::RES_W'(sct_pkg::VALUE_MIN)) begin
      value_nxt = sct_pkg::VALUE_MIN;
    end else begin
      value_nxt = res4[sct_pkg::VALUE_W-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_bus.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Payload: load only when a word moves in, hold otherwise
  always_ff @(posedge clk) begin
    if (rdy1 && in_bus.valid) begin
      req1_r <= in_bus.req_type;
      ang1_r <= in_bus.angle;
    end
    if (rdy2 && v1_r) begin
      phase2_r <= phase_nxt;
    end
    if (rdy3 && v2_r) begin
      lo3_r <= lo_nxt;
      d3_r  <= d_nxt;
      f3_r  <= phase2_r[sct_pkg::FRAC_W-1:0];
    end
    if (rdy4 && v3_r) begin
      lo4_r   <= lo3_r;
      prod4_r <= prod_nxt;
    end
    if (rdy5 && v4_r) begin
      value5_r <= value_nxt;
    end
  end

endmodule

`default_nettype wire
